/* rtl/prf_pkg.sv */
// ----------------------------------------------------------------------------
// prf_pkg
// Shared types, character codes and the binary-to-bcd helper for the point
// record formatter.
// ----------------------------------------------------------------------------
package prf_pkg;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam logic [15:0] Y_MAX = 16'd9999;

   localparam int unsigned REC_LEN = 12;
   localparam int unsigned CNT_W   = 4;
   localparam logic [CNT_W-1:0] LAST_IDX = 4'd11;
   localparam logic [CNT_W-1:0] TAB_IDX  = 4'd5;

   // converted point handed from the conversion pipe to the formatter
   typedef struct packed {
      logic [19:0] x_bcd;   // five digits, most significant in [19:16]
      logic [15:0] y_bcd;   // four digits, most significant in [15:12]
      logic        y_clamped;
   } prf_digits_type;

   // eight shift-add-3 steps of double dabble, msb of bits first
   function automatic logic [19:0] prf_dabble8(input logic [19:0] bcd_in,
                                               input logic [7:0]  bits);
      logic [19:0] b;
      int i;
      int d;
      b = bcd_in;
      for (i = 7; i >= 0; i--) begin
         for (d = 0; d < 5; d++) begin
            if (b[4*d +: 4] >= 4'd5) begin
               b[4*d +: 4] = b[4*d +: 4] + 4'd3;
            end
         end
         b = {b[18:0], bits[i]};
      end
      return b;
   endfunction

   function automatic logic prf_bcd_ok(input logic [19:0] bcd);
      logic ok;
      int d;
      ok = 1'b1;
      for (d = 0; d < 5; d++) begin
         if (bcd[4*d +: 4] > 4'd9) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

endpackage

/* rtl/point_record_formatter.sv */
// ----------------------------------------------------------------------------
// point_record_formatter
// Formats one (x, y) point into a 12-byte ASCII record on a byte stream.
// ----------------------------------------------------------------------------
// Each point accepted on req_ becomes the bytes: x as five right-aligned
// decimal digits, tab, y as four digits (clamped to 9999, tuser set on the
// whole record when clamped), carriage return, line feed with tlast. Leading
// zeros print as spaces; the last digit of each number always prints. The
// byte-wide output serializer sets the rate, loading the next record as the
// last byte of the one before is taken; the point passes through the clamp
// register (loaded at the accepting edge), two conversion stages, the record
// register and the serializer, and up to five points are held in flight, so
// req_tready stays high until four points wait behind the record being
// shifted out.
// ----------------------------------------------------------------------------
module point_record_formatter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [15:0] x_value, [31:16] y_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] out_byte
   output logic        rsp_tlast,
   output logic        rsp_tuser     // [0] y_clamped
);

   logic                    cv_valid;
   logic                    cv_ready;
   prf_pkg::prf_digits_type cv_data;

   prf_convert u_convert (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .up_x     (req_tdata[15:0]),
      .up_y     (req_tdata[31:16]),
      .dn_valid (cv_valid),
      .dn_ready (cv_ready),
      .dn_data  (cv_data)
   );

   prf_format u_format (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (cv_valid),
      .up_ready   (cv_ready),
      .up_data    (cv_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* rtl/prf_convert.sv */
// ----------------------------------------------------------------------------
// prf_convert
// Three-stage conversion pipe: clamp y, then double dabble of the high
// bytes, then of the low bytes, giving decimal digits of x and y.
// ----------------------------------------------------------------------------
module prf_convert (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  logic [15:0]            up_x,
   input  logic [15:0]            up_y,
   output logic                   dn_valid,
   input  logic                   dn_ready,
   output prf_pkg::prf_digits_type dn_data
);

   // stage 1: clamp
   logic        s1_valid_ff;
   logic [15:0] s1_x_ff;
   logic [15:0] s1_y_ff;
   logic        s1_flag_ff;
   // stage 2: high bytes converted
   logic        s2_valid_ff;
   logic [19:0] s2_xbcd_ff;
   logic [19:0] s2_ybcd_ff;
   logic [7:0]  s2_xlo_ff;
   logic [7:0]  s2_ylo_ff;
   logic        s2_flag_ff;
   // stage 3: all digits
   logic                   s3_valid_ff;
   prf_pkg::prf_digits_type s3_data_ff;

   logic        s1_ready;
   logic        s2_ready;
   logic        s3_ready;
   logic        y_over;
   logic [19:0] xbcd_in;
   logic [19:0] ybcd_in;
   logic [19:0] xbcd_fin;
   logic [19:0] ybcd_fin;

   assign s3_ready = !s3_valid_ff || dn_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign up_ready = s1_ready;

   assign y_over   = up_y > prf_pkg::Y_MAX;
   assign xbcd_in  = prf_pkg::prf_dabble8(20'd0, s1_x_ff[15:8]);
   assign ybcd_in  = prf_pkg::prf_dabble8(20'd0, s1_y_ff[15:8]);
   assign xbcd_fin = prf_pkg::prf_dabble8(s2_xbcd_ff, s2_xlo_ff);
   assign ybcd_fin = prf_pkg::prf_dabble8(s2_ybcd_ff, s2_ylo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= up_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && up_valid) begin
         s1_x_ff    <= up_x;
         s1_y_ff    <= y_over ? prf_pkg::Y_MAX : up_y;
         s1_flag_ff <= y_over;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_xbcd_ff <= xbcd_in;
         s2_ybcd_ff <= ybcd_in;
         s2_xlo_ff  <= s1_x_ff[7:0];
         s2_ylo_ff  <= s1_y_ff[7:0];
         s2_flag_ff <= s1_flag_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_data_ff.x_bcd     <= xbcd_fin;
         s3_data_ff.y_bcd     <= ybcd_fin[15:0];
         s3_data_ff.y_clamped <= s2_flag_ff;
      end
   end

   assign dn_valid = s3_valid_ff;
   assign dn_data  = s3_data_ff;

   a_clamp_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_y_ff <= prf_pkg::Y_MAX)
                      && (!s1_flag_ff || s1_y_ff == prf_pkg::Y_MAX))
      else $error("clamped y out of range");

   a_digits_ok: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> prf_pkg::prf_bcd_ok(s3_data_ff.x_bcd)
                      && prf_pkg::prf_bcd_ok({4'd0, s3_data_ff.y_bcd}))
      else $error("non-decimal digit after conversion");

endmodule

/* rtl/prf_format.sv */
// ----------------------------------------------------------------------------
// prf_format
// Builds the 12-byte text record with leading-zero blanking into a record
// register, then shifts it out one byte per transaction.
// ----------------------------------------------------------------------------
module prf_format (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  prf_pkg::prf_digits_type up_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tuser
);

   localparam int unsigned REC_W = 8 * prf_pkg::REC_LEN;

   logic                       rec_valid_ff;
   logic [REC_W-1:0]           rec_data_ff;
   logic                       rec_flag_ff;
   logic [REC_W-1:0]           rec_in;

   logic                       ser_valid_ff;
   logic [REC_W-1:0]           ser_buf_ff;
   logic [prf_pkg::CNT_W-1:0]  ser_cnt_ff;
   logic                       ser_flag_ff;

   logic                       rec_ready;
   logic                       ser_load;
   logic                       out_fire;
   logic                       out_last;
   logic [3:0]                 xd [5];
   logic [3:0]                 yd [4];
   logic [4:0]                 xblank;
   logic [3:0]                 yblank;

   assign out_fire  = rsp_tvalid && rsp_tready;
   assign out_last  = ser_cnt_ff == prf_pkg::LAST_IDX;
   assign ser_load  = rec_valid_ff && (!ser_valid_ff || (out_fire && out_last));
   assign rec_ready = !rec_valid_ff || ser_load;
   assign up_ready  = rec_ready;

   // record assembly, byte 0 in the low bits
   always_comb begin
      for (int i = 0; i < 5; i++) begin
         xd[i] = up_data.x_bcd[4*(4-i) +: 4];
      end
      for (int i = 0; i < 4; i++) begin
         yd[i] = up_data.y_bcd[4*(3-i) +: 4];
      end
      // a digit other than the last blanks when it and every digit before it are zero
      xblank[0] = xd[0] == 4'd0;
      for (int i = 1; i < 4; i++) begin
         xblank[i] = xblank[i-1] && (xd[i] == 4'd0);
      end
      xblank[4] = 1'b0;
      yblank[0] = yd[0] == 4'd0;
      for (int i = 1; i < 3; i++) begin
         yblank[i] = yblank[i-1] && (yd[i] == 4'd0);
      end
      yblank[3] = 1'b0;
      rec_in = '0;
      for (int i = 0; i < 5; i++) begin
         rec_in[8*i +: 8] = xblank[i] ? prf_pkg::CH_SPACE : (prf_pkg::CH_ZERO | {4'd0, xd[i]});
      end
      rec_in[8*5 +: 8] = prf_pkg::CH_TAB;
      for (int i = 0; i < 4; i++) begin
         rec_in[8*(6+i) +: 8] = yblank[i] ? prf_pkg::CH_SPACE
                                          : (prf_pkg::CH_ZERO | {4'd0, yd[i]});
      end
      rec_in[8*10 +: 8] = prf_pkg::CH_CR;
      rec_in[8*11 +: 8] = prf_pkg::CH_LF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_valid_ff <= 1'b0;
         ser_valid_ff <= 1'b0;
         ser_cnt_ff   <= '0;
      end else begin
         if (rec_ready) begin
            rec_valid_ff <= up_valid;
         end
         if (ser_load) begin
            ser_valid_ff <= 1'b1;
            ser_cnt_ff   <= '0;
         end else if (out_fire) begin
            if (out_last) begin
               ser_valid_ff <= 1'b0;
               ser_cnt_ff   <= '0;
            end else begin
               ser_cnt_ff <= ser_cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rec_ready && up_valid) begin
         rec_data_ff <= rec_in;
         rec_flag_ff <= up_data.y_clamped;
      end
      if (ser_load) begin
         ser_buf_ff  <= rec_data_ff;
         ser_flag_ff <= rec_flag_ff;
      end else if (out_fire) begin
         ser_buf_ff <= {8'd0, ser_buf_ff[REC_W-1:8]};
      end
   end

   assign rsp_tvalid = ser_valid_ff;
   assign rsp_tdata  = ser_buf_ff[7:0];
   assign rsp_tlast  = out_last;
   assign rsp_tuser  = ser_flag_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      ser_valid_ff |-> ser_cnt_ff <= prf_pkg::LAST_IDX)
      else $error("byte counter beyond record");

   a_last_is_lf: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tdata == prf_pkg::CH_LF)
      else $error("record does not end in line feed");

   a_tab_place: assert property (@(posedge clock) disable iff (reset)
      (ser_valid_ff && ser_cnt_ff == prf_pkg::TAB_IDX) |-> rsp_tdata == prf_pkg::CH_TAB)
      else $error("separator missing between numbers");

endmodule

/* tb/sv/point_record_formatter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_record_formatter_tb
// Self-checking testbench for the point record formatter.
// ----------------------------------------------------------------------------
// Points go in on the req_ stream and twelve-byte text records come back on
// the rsp_ stream. A table of directed points comes first. Some rows carry the
// record text written out by hand and the rest use the behavioral formatter.
// Random points follow, with magnitudes spread over every digit count and
// over the clamp range. Both streams insert random waits, with quiet stretches
// that have none. Every returned byte is checked against the oldest expected
// byte for character, tlast and tuser.
// ----------------------------------------------------------------------------
module point_record_formatter_tb;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 11;
   localparam int RANDOM_POINTS = 140;
   localparam int MAX_WAIT      = 13;
   localparam int STALL_LIMIT   = 4000;
   localparam int DRAIN_CYCLES  = 30;
   localparam int DIRECTED_ROWS = 21;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       clamped;
   } record_byte_type;

   // hand_typed rows carry the record text; the others go through the formatter
   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic        hand_typed;
      logic [39:0] x_text;
      logic [31:0] y_text;
      logic        clamped;
   } point_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [15:0] x_value, [31:16] y_value
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // [7:0] out_byte
   logic        rsp_tlast;
   logic        rsp_tuser;    // [0] y_clamped

   record_byte_type pending_bytes[$];
   int unsigned     fail_count;
   int unsigned     points_sent;
   int unsigned     clamped_points;
   int unsigned     bytes_checked;
   int unsigned     idle_cycles;
   bit              quiet_phase;

   point_row_type directed_rows [DIRECTED_ROWS] = '{
      '{16'd0,     16'd0,     1'b1, "    0", "   0", 1'b0},
      '{16'd65535, 16'd9999,  1'b1, "65535", "9999", 1'b0},
      '{16'd65535, 16'd65535, 1'b1, "65535", "9999", 1'b1},
      '{16'd0,     16'd10000, 1'b1, "    0", "9999", 1'b1},
      '{16'd9,     16'd9,     1'b1, "    9", "   9", 1'b0},
      '{16'd10,    16'd10,    1'b1, "   10", "  10", 1'b0},
      '{16'd10000, 16'd1000,  1'b1, "10000", "1000", 1'b0},
      '{16'd12345, 16'd6789,  1'b1, "12345", "6789", 1'b0},
      '{16'd9999,  16'd999,   1'b0, '0, '0, 1'b0},
      '{16'd99,    16'd99,    1'b0, '0, '0, 1'b0},
      '{16'd100,   16'd100,   1'b0, '0, '0, 1'b0},
      '{16'd1000,  16'd9998,  1'b0, '0, '0, 1'b0},
      '{16'd0,     16'd1,     1'b0, '0, '0, 1'b0},
      '{16'd1,     16'd0,     1'b0, '0, '0, 1'b0},
      '{16'hAAAA,  16'h5555,  1'b0, '0, '0, 1'b0},
      '{16'h5555,  16'hAAAA,  1'b0, '0, '0, 1'b0},
      '{16'h8000,  16'h8000,  1'b0, '0, '0, 1'b0},
      '{16'd50001, 16'd10001, 1'b0, '0, '0, 1'b0},
      '{16'd65535, 16'd0,     1'b0, '0, '0, 1'b0},
      '{16'd40960, 16'd5,     1'b0, '0, '0, 1'b0},
      '{16'd7,     16'd9990,  1'b0, '0, '0, 1'b0}
   };

   point_record_formatter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   function automatic int draw_wait();
      if (quiet_phase) begin
         return 0;
      end
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // expected text of one point: x in five places, tab, y in four, cr, lf
   function automatic void format_point(input logic [15:0] x, input logic [15:0] y);
      logic [7:0]  text [prf_pkg::REC_LEN];
      logic        clamped;
      int unsigned value;
      int          base;
      int          width;
      int          f;
      int          k;
      bit          leading;
      clamped = (y > prf_pkg::Y_MAX);
      for (f = 0; f < 2; f++) begin
         base  = (f == 0) ? 0 : 6;
         width = (f == 0) ? 5 : 4;
         value = 32'((f == 0) ? x : (clamped ? prf_pkg::Y_MAX : y));
         for (k = width - 1; k >= 0; k--) begin
            text[base + k] = prf_pkg::CH_ZERO + 8'(value % 10);
            value = value / 10;
         end
         // blank leading zeros but always keep the units digit
         leading = 1'b1;
         for (k = 0; k < width - 1; k++) begin
            if (leading && text[base + k] == prf_pkg::CH_ZERO) begin
               text[base + k] = prf_pkg::CH_SPACE;
            end else begin
               leading = 1'b0;
            end
         end
      end
      text[prf_pkg::TAB_IDX]  = prf_pkg::CH_TAB;
      text[10]                = prf_pkg::CH_CR;
      text[prf_pkg::LAST_IDX] = prf_pkg::CH_LF;
      for (k = 0; k < prf_pkg::REC_LEN; k++) begin
         pending_bytes.push_back('{text[k], k == prf_pkg::LAST_IDX, clamped});
      end
      if (clamped) begin
         clamped_points++;
      end
   endfunction

   // one point on req_, leaves valid high at the next falling edge
   task automatic send_point(input logic [15:0] x, input logic [15:0] y,
                             input point_row_type row);
      int gap;
      int k;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      do @(posedge clock); while (!req_tready);
      if (row.hand_typed) begin
         for (k = 0; k < prf_pkg::REC_LEN; k++) begin
            pending_bytes.push_back('{
               (k < 5)  ? row.x_text[8*(4-k) +: 8] :
               (k == prf_pkg::TAB_IDX) ? prf_pkg::CH_TAB :
               (k < 10) ? row.y_text[8*(9-k) +: 8] :
               (k == prf_pkg::LAST_IDX) ? prf_pkg::CH_LF : prf_pkg::CH_CR,
               k == prf_pkg::LAST_IDX, row.clamped});
         end
         if (row.clamped) begin
            clamped_points++;
         end
      end else begin
         format_point(x, y);
      end
      points_sent++;
      @(negedge clock);
   endtask

   function automatic logic [15:0] draw_magnitude(input int digits);
      int unsigned top;
      top = (digits >= 5) ? 65535 : (10 ** digits) - 1;
      return 16'($urandom_range(0, top));
   endfunction

   // sink side: random stall before each byte
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      record_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bytes.size() == 0) begin
            $error("unexpected byte 0x%02h with no record pending", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_bytes.pop_front();
            bytes_checked++;
            if (rsp_tdata !== want.ch) begin
               $error("out_byte: expected 0x%02h, got 0x%02h", want.ch, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_byte: expected %0b, got %0b", want.last, rsp_tlast);
               fail_count++;
            end
            if (rsp_tuser !== want.clamped) begin
               $error("y_clamped: expected %0b, got %0b", want.clamped, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      point_row_type noise_row;
      logic [15:0]   x;
      logic [15:0]   y;
      int            n;
      fail_count     = 0;
      points_sent    = 0;
      clamped_points = 0;
      bytes_checked  = 0;
      idle_cycles    = 0;
      quiet_phase    = 1'b0;
      noise_row      = '0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIRECTED_ROWS; n++) begin
         send_point(directed_rows[n].x, directed_rows[n].y, directed_rows[n]);
      end

      for (n = 0; n < RANDOM_POINTS; n++) begin
         // two stretches run back to back on both streams
         quiet_phase = (n >= 40 && n < 70) || (n >= 110 && n < 125);
         case ($urandom_range(0, 9)) inside
            [0:6]:   x = draw_magnitude($urandom_range(1, 5));
            7:       x = 16'hFFFF - 16'($urandom_range(0, 15));
            default: x = 16'($urandom);
         endcase
         case ($urandom_range(0, 9)) inside
            [0:5]:   y = draw_magnitude($urandom_range(1, 4));
            6:       y = $urandom_range(0, 1) ? 16'd10000 : prf_pkg::Y_MAX;
            [7:8]:   y = 16'($urandom_range(10000, 65535));
            default: y = 16'($urandom);
         endcase
         send_point(x, y, noise_row);
      end
      quiet_phase = 1'b0;
      req_tvalid <= 1'b0;

      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d points (%0d from the table), %0d with y clamped",
               points_sent, DIRECTED_ROWS, clamped_points);
      $display("checked %0d record bytes, %0d mismatches", bytes_checked, fail_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/prf_pkg.sv
rtl/prf_convert.sv
rtl/prf_format.sv
rtl/point_record_formatter.sv
tb/sv/point_record_formatter_tb.sv
